// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the verification checker of the blitter.
// Depends on nothing; included by every file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is low.
`define CKB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while the active-low reset is low.
`define CKB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ckb_pkg.sv =====
// Package of the colour-key brush blitter: sizes, register codes, types, helpers.
// Depends on nothing; used by every RTL module of the blitter.
`timescale 1ns / 1ps

package ckb_pkg;

  // Internal address width and the largest horizontal zoom.
  localparam int ADDR_BITS = 20;
  localparam int MAX_ZOOM  = 16;

  // Widths that follow from the constants above.
  localparam int ZOOM_W = $clog2(MAX_ZOOM + 1);
  localparam int K_W    = (MAX_ZOOM > 1) ? $clog2(MAX_ZOOM) : 1;
  localparam int SUM_W  = ADDR_BITS + 2;

  // Depth of the descriptor queue between the front and back parts.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Fixed port widths.
  localparam int OUT_ADDR_W = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 3;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_STRIDE = 3'd0,
    REG_DEST_BASE     = 3'd1,
    REG_SRC_WIDTH     = 3'd2,
    REG_OUT_HEIGHT    = 3'd3,
    REG_ZOOM_FACTOR   = 3'd4,
    REG_KEY_COLOR     = 3'd5,
    REG_FILL_COLOR    = 3'd6,
    REG_DRAW_MODE     = 3'd7
  } cfg_reg_t;

  // One classified brush pixel, handed from the front to the back part.
  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [7:0]           value;
    logic                 visible;
    logic [K_W-1:0]       last_k;
    logic                 rect_end;
  } desc_t;

  // One framebuffer write as it leaves the block.
  typedef struct packed {
    logic [OUT_ADDR_W-1:0] pixel_address;
    logic [7:0]            pixel_value;
    logic                  write_enable;
    logic                  last_of_run;
    logic                  blit_done;
  } res_t;

  // Width and height limits: zero acts as one, anything above 4096 as 4096.
  function automatic logic [12:0] clamp_dim(input logic [12:0] v);
    if (v == 13'd0) begin
      return 13'd1;
    end else if (v > 13'd4096) begin
      return 13'd4096;
    end else begin
      return v;
    end
  endfunction

  // Zoom limits: zero acts as one, anything above MAX_ZOOM as MAX_ZOOM.
  function automatic logic [ZOOM_W-1:0] clamp_zoom(input logic [4:0] z);
    logic [6:0] zw;
    zw = {2'b00, z};
    if (zw == 7'd0) begin
      return ZOOM_W'(1);
    end else if (zw > 7'(MAX_ZOOM)) begin
      return ZOOM_W'(MAX_ZOOM);
    end else begin
      return ZOOM_W'(zw);
    end
  endfunction

endpackage

// ===== rtl/ckb_front.sv =====
// Front part of the blitter: configuration registers, row and column tracking,
// and classification of each accepted brush pixel. Depends on ckb_pkg.
`timescale 1ns / 1ps

module ckb_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ckb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ckb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_push,
  input  logic [7:0]                       in_src_pixel,
  output logic                             in_full,
  input  logic                             q_full,
  output logic                             desc_push,
  output ckb_pkg::desc_t                   desc
);

  // Configuration registers.
  logic [12:0] screen_stride_r;
  logic [19:0] dest_base_r;
  logic [12:0] src_width_r;
  logic [12:0] out_height_r;
  logic [4:0]  zoom_factor_r;
  logic [7:0]  key_color_r;
  logic [7:0]  fill_color_r;
  logic        draw_mode_r;

  // Position state of the rectangle.
  logic [11:0]                   col_count_r, col_count_nxt;
  logic [11:0]                   row_count_r, row_count_nxt;
  logic [ckb_pkg::ADDR_BITS-1:0] row_start_addr_r, row_start_addr_nxt;
  logic [ckb_pkg::ADDR_BITS-1:0] next_addr_r, next_addr_nxt;

  logic [12:0]                   width_c;
  logic [12:0]                   height_c;
  logic [ckb_pkg::ZOOM_W-1:0]    zoom_c;
  logic                          visible;
  logic                          row_end;
  logic                          rect_end;
  logic                          accept;
  logic                          rearm;
  logic [ckb_pkg::ADDR_BITS-1:0] base_addr;

  // The queue sets the input side's back-pressure.
  assign in_full   = q_full;
  assign accept    = in_push && !q_full;
  assign desc_push = accept;

  // Writing the destination base restarts the rectangle.
  assign rearm     = cfg_we && (ckb_pkg::cfg_reg_t'(cfg_index) == ckb_pkg::REG_DEST_BASE);
  assign base_addr = ckb_pkg::ADDR_BITS'(dest_base_r);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_stride_r <= 13'd640;
      dest_base_r     <= 20'd0;
      src_width_r     <= 13'd1;
      out_height_r    <= 13'd1;
      zoom_factor_r   <= 5'd1;
      key_color_r     <= 8'd0;
      fill_color_r    <= 8'd0;
      draw_mode_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (ckb_pkg::cfg_reg_t'(cfg_index))
        ckb_pkg::REG_SCREEN_STRIDE: screen_stride_r <= cfg_data[12:0];
        ckb_pkg::REG_DEST_BASE:     dest_base_r     <= cfg_data[19:0];
        ckb_pkg::REG_SRC_WIDTH:     src_width_r     <= cfg_data[12:0];
        ckb_pkg::REG_OUT_HEIGHT:    out_height_r    <= cfg_data[12:0];
        ckb_pkg::REG_ZOOM_FACTOR:   zoom_factor_r   <= cfg_data[4:0];
        ckb_pkg::REG_KEY_COLOR:     key_color_r     <= cfg_data[7:0];
        ckb_pkg::REG_FILL_COLOR:    fill_color_r    <= cfg_data[7:0];
        ckb_pkg::REG_DRAW_MODE:     draw_mode_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Classification of the incoming pixel against the current limits.
  always_comb begin
    width_c  = ckb_pkg::clamp_dim(src_width_r);
    height_c = ckb_pkg::clamp_dim(out_height_r);
    zoom_c   = ckb_pkg::clamp_zoom(zoom_factor_r);
    visible  = (in_src_pixel != key_color_r);
    row_end  = ((13'(col_count_r) + 13'd1) >= width_c);
    rect_end = row_end && ((13'(row_count_r) + 13'd1) >= height_c);

    desc.base     = next_addr_r;
    desc.value    = visible ? (draw_mode_r ? fill_color_r : in_src_pixel) : 8'd0;
    desc.visible  = visible;
    desc.last_k   = ckb_pkg::K_W'(zoom_c - ckb_pkg::ZOOM_W'(1));
    desc.rect_end = rect_end;
  end

  // Position update after each transfer, or a restart on a base write.
  always_comb begin
    col_count_nxt      = col_count_r;
    row_count_nxt      = row_count_r;
    row_start_addr_nxt = row_start_addr_r;
    next_addr_nxt      = next_addr_r;
    if (rearm) begin
      col_count_nxt      = 12'd0;
      row_count_nxt      = 12'd0;
      row_start_addr_nxt = ckb_pkg::ADDR_BITS'(cfg_data[19:0]);
      next_addr_nxt      = ckb_pkg::ADDR_BITS'(cfg_data[19:0]);
    end else if (accept) begin
      if (rect_end) begin
        col_count_nxt      = 12'd0;
        row_count_nxt      = 12'd0;
        row_start_addr_nxt = base_addr;
        next_addr_nxt      = base_addr;
      end else if (row_end) begin
        col_count_nxt      = 12'd0;
        row_count_nxt      = row_count_r + 12'd1;
        row_start_addr_nxt = ckb_pkg::ADDR_BITS'(ckb_pkg::SUM_W'(row_start_addr_r)
                                                 + ckb_pkg::SUM_W'(screen_stride_r));
        next_addr_nxt      = row_start_addr_nxt;
      end else begin
        col_count_nxt = col_count_r + 12'd1;
        next_addr_nxt = next_addr_r + ckb_pkg::ADDR_BITS'(zoom_c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r      <= 12'd0;
      row_count_r      <= 12'd0;
      row_start_addr_r <= '0;
      next_addr_r      <= '0;
    end else begin
      col_count_r      <= col_count_nxt;
      row_count_r      <= row_count_nxt;
      row_start_addr_r <= row_start_addr_nxt;
      next_addr_r      <= next_addr_nxt;
    end
  end

endmodule

// ===== rtl/ckb_queue.sv =====
// Short descriptor queue that decouples the front part from the back part.
// Depends on ckb_pkg.
`timescale 1ns / 1ps

module ckb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ckb_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output ckb_pkg::desc_t head
);

  ckb_pkg::desc_t               mem_r [ckb_pkg::Q_DEPTH];
  logic [ckb_pkg::Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [ckb_pkg::Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [ckb_pkg::Q_CNT_W-1:0]  count_r, count_nxt;
  logic                         do_push;
  logic                         do_pop;

  assign full    = (count_r == ckb_pkg::Q_CNT_W'(ckb_pkg::Q_DEPTH));
  assign valid   = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Pointer and fill count update with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == ckb_pkg::Q_PTR_W'(ckb_pkg::Q_DEPTH - 1)) ? '0
                   : wr_ptr_r + ckb_pkg::Q_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == ckb_pkg::Q_PTR_W'(ckb_pkg::Q_DEPTH - 1)) ? '0
                   : rd_ptr_r + ckb_pkg::Q_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + ckb_pkg::Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - ckb_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ===== rtl/ckb_back.sv =====
// Back part of the blitter: expands each descriptor into its run of writes,
// one a cycle while the output register is empty or being popped, into the output register. Depends on ckb_pkg.
`timescale 1ns / 1ps

module ckb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  ckb_pkg::desc_t q_desc,
  output logic           q_pop,
  input  logic           out_pop,
  output logic           out_empty,
  output ckb_pkg::res_t  res
);

  ckb_pkg::desc_t          cur_r;
  logic                    cur_valid_r, cur_valid_nxt;
  logic [ckb_pkg::K_W-1:0] k_r, k_nxt;
  logic                    out_valid_r, out_valid_nxt;
  ckb_pkg::res_t           res_r;
  logic                    out_ready;
  logic                    step;
  logic                    cur_last;

  // A write moves into the output register when it is empty or being popped.
  assign out_ready = !out_valid_r || out_pop;
  assign step      = cur_valid_r && out_ready;
  assign cur_last  = (k_r == cur_r.last_k);
  assign q_pop     = q_valid && (!cur_valid_r || (step && cur_last));
  assign out_empty = !out_valid_r;
  assign res       = res_r;

  // Run sequencing.
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      k_nxt         = '0;
    end else if (step) begin
      if (cur_last) begin
        cur_valid_nxt = 1'b0;
      end else begin
        k_nxt = k_r + ckb_pkg::K_W'(1);
      end
    end
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Current descriptor and output payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_desc;
    end
    if (step) begin
      res_r.pixel_address <= ckb_pkg::OUT_ADDR_W'(cur_r.base + ckb_pkg::ADDR_BITS'(k_r));
      res_r.pixel_value   <= cur_r.value;
      res_r.write_enable  <= cur_r.visible;
      res_r.last_of_run   <= cur_last;
      res_r.blit_done     <= cur_last && cur_r.rect_end;
    end
  end

endmodule

// ===== rtl/color_key_brush_blitter_core.sv =====
// Top level of the colour-key brush blitter: front part, descriptor queue and
// back part. Depends on ckb_pkg, ckb_front, ckb_queue and ckb_back.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// in_       input      in_push / in_full  in_src_pixel
// out_      output     out_empty/out_pop  pixel_address, pixel_value, write_enable,
//                                         last_of_run, blit_done
// cfg_      input      cfg_we             cfg_index, cfg_data
//
// Each pixel yields its clamped zoom_factor in writes; the back part issues one
// write per cycle while the output is free or popped, so at zoom 1 one pixel per
// cycle is taken. Each pixel passes the queue, the current-descriptor register
// and the output register. Reset is synchronous and active low; no clearing pass
// follows it. A stalled output holds its write; the two-entry queue fills meanwhile.

module color_key_brush_blitter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [7:0]                     in_src_pixel,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [19:0]                    out_pixel_address,
  output logic [7:0]                     out_pixel_value,
  output logic                           out_write_enable,
  output logic                           out_last_of_run,
  output logic                           out_blit_done,
  input  logic                           cfg_we,
  input  logic [ckb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ckb_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic           q_full;
  logic           desc_push;
  ckb_pkg::desc_t desc;
  logic           q_valid;
  logic           q_pop;
  ckb_pkg::desc_t q_head;
  ckb_pkg::res_t  res;

  ckb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_push      (in_push),
    .in_src_pixel (in_src_pixel),
    .in_full      (in_full),
    .q_full       (q_full),
    .desc_push    (desc_push),
    .desc         (desc)
  );

  ckb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (desc_push),
    .push_desc (desc),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  ckb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_desc    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .res       (res)
  );

  // Result fields onto their ports.
  assign out_pixel_address = res.pixel_address;
  assign out_pixel_value   = res.pixel_value;
  assign out_write_enable  = res.write_enable;
  assign out_last_of_run   = res.last_of_run;
  assign out_blit_done     = res.blit_done;

endmodule

// ===== rtl/ckb_checker.sv =====
// Port-level checker of the colour-key brush blitter, bound to the top level.
// Depends on assert_macros.svh and color_key_brush_blitter_core.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ckb_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_empty,
  input logic                           out_pop,
  input logic [19:0]                    out_pixel_address,
  input logic [7:0]                     out_pixel_value,
  input logic                           out_write_enable,
  input logic                           out_last_of_run,
  input logic                           out_blit_done
);

  // A waiting write that is not taken stays on the ports unchanged.
  `CKB_ASSERT_NEXT(a_out_hold, clk, rst_n, (!out_empty && !out_pop), (!out_empty && $stable(out_pixel_address) && $stable(out_pixel_value) && $stable(out_write_enable) && $stable(out_last_of_run) && $stable(out_blit_done)), "stalled result changed")

  // The end of the rectangle always closes a run.
  `CKB_ASSERT_NOW(a_done_last, clk, rst_n, (!out_empty && out_blit_done), out_last_of_run, "blit_done without last_of_run")

  // A transparent skip carries a zero value.
  `CKB_ASSERT_NOW(a_skip_zero, clk, rst_n, (!out_empty && !out_write_enable), (out_pixel_value == 8'd0), "skipped write with non-zero value")

endmodule

bind color_key_brush_blitter_core ckb_checker u_ckb_checker (.*);
